### rtl/sab_pkg.sv
// ----------------------------------------------------------------------------
// Suffix automaton builder package
// Shared widths, default sizes and the command and status words that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package sab_pkg;

    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_ALPHABET  = 26;

    localparam int SYMBOL_W     = 5;
    localparam int END_STATE_W  = 10;
    localparam int END_LENGTH_W = 10;
    localparam int NODE_TOTAL_W = 11;

    typedef struct packed {
        logic load;
        logic t_clr;
        logic t_rd_pc;
        logic t_copy;
        logic t_wr_nn;
        logic t_wr_k;
        logic l_rd_p;
        logic l_rd_q;
        logic l_wr_k;
        logic s_rd_p;
        logic s_rd_q;
        logic s_wr_nn_zero;
        logic s_wr_k_q;
        logic s_wr_q_k;
        logic s_wr_nn_ret;
        logic alloc_nn;
        logic alloc_k;
        logic set_q;
        logic set_want;
        logic p_link;
        logic ret_q;
        logic ret_k;
        logic ret_nn;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic refused;
        logic edge_zero;
        logic edge_is_q;
        logic p_root;
        logic len_ok;
        logic copy_last;
        logic fresh;
        logic out_free;
    } status_t;

endpackage

### rtl/sab_in_if.sv
// ----------------------------------------------------------------------------
// Symbol channel
// Carries one symbol word and its restart flag with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sab_in_if;
    import sab_pkg::*;

    logic                valid;
    logic                ready;
    logic [SYMBOL_W-1:0] symbol;
    logic                restart;

    modport source
    (
        output valid,
        output symbol,
        output restart,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  symbol,
        input  restart,
        output ready
    );
endinterface

### rtl/sab_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Carries one result word of the builder with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sab_out_if;
    import sab_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [END_STATE_W-1:0]  end_state;
    logic [END_LENGTH_W-1:0] end_length;
    logic [NODE_TOTAL_W-1:0] node_total;
    logic                    full_res;

    modport source
    (
        output valid,
        output end_state,
        output end_length,
        output node_total,
        output full_res,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  end_state,
        input  end_length,
        input  node_total,
        input  full_res,
        output ready
    );
endinterface

### rtl/sab_ctrl.sv
// ----------------------------------------------------------------------------
// Suffix automaton builder controller
// Sequences the clearing pass, the fresh-node walk, the clone and the
// redirect walk, issuing one memory step per cycle unless a result waits.
// ----------------------------------------------------------------------------
module sab_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sab_pkg::status_t st,
    output sab_pkg::cmd_t    cmd
);
    import sab_pkg::*;

    typedef enum logic [19:0] {
        ST_CLEAR = 20'h00001,
        ST_IDLE  = 20'h00002,
        ST_START = 20'h00004,
        ST_CHK   = 20'h00008,
        ST_WRD   = 20'h00010,
        ST_WCHK  = 20'h00020,
        ST_WLNK  = 20'h00040,
        ST_SL1   = 20'h00080,
        ST_SL2   = 20'h00100,
        ST_SL3   = 20'h00200,
        ST_CP    = 20'h00400,
        ST_LNK1  = 20'h00800,
        ST_LNK2  = 20'h01000,
        ST_LNK3  = 20'h02000,
        ST_RRD   = 20'h04000,
        ST_RCHK  = 20'h08000,
        ST_RLNK  = 20'h10000,
        ST_RDONE = 20'h20000,
        ST_RET   = 20'h40000,
        ST_EMIT  = 20'h80000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.t_clr = 1'b1;
                if (st.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (st.refused)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.t_rd_pc = 1'b1;
                    cmd.l_rd_p  = 1'b1;
                    state_next  = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (st.edge_zero)
                begin
                    cmd.alloc_nn = 1'b1;
                    state_next   = ST_WRD;
                end
                else
                begin
                    cmd.set_q  = 1'b1;
                    state_next = ST_SL1;
                end
            end
            ST_WRD:
            begin
                cmd.t_rd_pc = 1'b1;
                state_next  = ST_WCHK;
            end
            ST_WCHK:
            begin
                if (!st.edge_zero)
                begin
                    cmd.set_q  = 1'b1;
                    state_next = ST_SL1;
                end
                else
                begin
                    cmd.t_wr_nn = 1'b1;
                    if (st.p_root)
                    begin
                        cmd.s_wr_nn_zero = 1'b1;
                        cmd.ret_nn       = 1'b1;
                        state_next       = ST_EMIT;
                    end
                    else
                    begin
                        cmd.s_rd_p = 1'b1;
                        state_next = ST_WLNK;
                    end
                end
            end
            ST_WLNK:
            begin
                cmd.p_link = 1'b1;
                state_next = ST_WRD;
            end
            ST_SL1:
            begin
                cmd.l_rd_p = 1'b1;
                state_next = ST_SL2;
            end
            ST_SL2:
            begin
                cmd.set_want = 1'b1;
                cmd.l_rd_q   = 1'b1;
                state_next   = ST_SL3;
            end
            ST_SL3:
            begin
                if (st.len_ok)
                begin
                    cmd.ret_q  = 1'b1;
                    state_next = ST_RET;
                end
                else
                begin
                    cmd.alloc_k = 1'b1;
                    state_next  = ST_CP;
                end
            end
            ST_CP:
            begin
                cmd.t_copy = 1'b1;
                if (st.copy_last)
                begin
                    state_next = ST_LNK1;
                end
            end
            ST_LNK1:
            begin
                cmd.s_rd_q = 1'b1;
                cmd.l_wr_k = 1'b1;
                state_next = ST_LNK2;
            end
            ST_LNK2:
            begin
                cmd.s_wr_k_q = 1'b1;
                state_next   = ST_LNK3;
            end
            ST_LNK3:
            begin
                cmd.s_wr_q_k = 1'b1;
                state_next   = ST_RRD;
            end
            ST_RRD:
            begin
                cmd.t_rd_pc = 1'b1;
                state_next  = ST_RCHK;
            end
            ST_RCHK:
            begin
                if (st.edge_is_q)
                begin
                    cmd.t_wr_k = 1'b1;
                    if (st.p_root)
                    begin
                        state_next = ST_RDONE;
                    end
                    else
                    begin
                        cmd.s_rd_p = 1'b1;
                        state_next = ST_RLNK;
                    end
                end
                else
                begin
                    state_next = ST_RDONE;
                end
            end
            ST_RLNK:
            begin
                cmd.p_link = 1'b1;
                state_next = ST_RRD;
            end
            ST_RDONE:
            begin
                cmd.ret_k  = 1'b1;
                state_next = ST_RET;
            end
            ST_RET:
            begin
                if (st.fresh)
                begin
                    cmd.s_wr_nn_ret = 1'b1;
                    cmd.ret_nn      = 1'b1;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_clone_needs_node: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SL3 && !st.len_ok) |=> (state_reg == ST_CP))
        else $error("clone did not start its row copy");

    a_emit_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (state_reg == ST_IDLE))
        else $error("controller did not return to idle after a result");

    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_START))
        else $error("accepted word did not start processing");
endmodule

### rtl/sab_datapath.sv
// ----------------------------------------------------------------------------
// Suffix automaton builder datapath
// Holds the transition, length and suffix-link memories, the working node
// registers and the result register.
// ----------------------------------------------------------------------------
module sab_datapath #(
    parameter int MAX_NODES = sab_pkg::DEF_MAX_NODES,
    parameter int ALPHABET  = sab_pkg::DEF_ALPHABET
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  sab_pkg::cmd_t                     cmd,
    output sab_pkg::status_t                  st,
    input  logic [sab_pkg::SYMBOL_W-1:0]      symbol,
    input  logic                              restart,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [sab_pkg::END_STATE_W-1:0]   end_state,
    output logic [sab_pkg::END_LENGTH_W-1:0]  end_length,
    output logic [sab_pkg::NODE_TOTAL_W-1:0]  node_total,
    output logic                              full_res
);
    import sab_pkg::*;

    localparam int NW     = $clog2(MAX_NODES);
    localparam int CW     = $clog2(MAX_NODES + 1);
    localparam int AW     = $clog2(ALPHABET);
    localparam int IW     = $clog2(ALPHABET + 1);
    localparam int TDEPTH = MAX_NODES * ALPHABET;
    localparam int TAW    = $clog2(TDEPTH);

    function automatic logic [TAW-1:0] tab_addr(input logic [NW-1:0] node,
                                                input logic [IW-1:0] sym);
        tab_addr = TAW'(node) * TAW'(ALPHABET) + TAW'(sym);
    endfunction

    logic [NW-1:0]  tab_mem [TDEPTH];
    logic [NW-1:0]  len_mem [MAX_NODES];
    logic [NW-1:0]  link_mem [MAX_NODES];

    logic [NW-1:0]  tab_rdata_reg;
    logic [NW-1:0]  len_rdata_reg;
    logic           len_zero_reg;
    logic [NW-1:0]  link_rdata_reg;

    logic [AW-1:0]  c_reg;
    logic [NW-1:0]  p_reg;
    logic [NW-1:0]  q_reg;
    logic [NW-1:0]  nn_reg;
    logic [NW-1:0]  nn_len_reg;
    logic [NW-1:0]  k_reg;
    logic [NW-1:0]  want_reg;
    logic [NW-1:0]  r_reg;
    logic [NW-1:0]  r_len_reg;
    logic [IW-1:0]  idx_reg;
    logic [TAW-1:0] clr_reg;
    logic [CW-1:0]  cnt_reg;
    logic [NW-1:0]  cur_reg;
    logic [NW-1:0]  cur_len_reg;
    logic           skip_reg;
    logic           full_reg;
    logic           fresh_reg;
    logic           out_valid_reg;

    logic [NW-1:0]  len_val;
    logic           sym_bad;
    logic           no_room;
    logic           t_we;
    logic [TAW-1:0] t_wa;
    logic [NW-1:0]  t_wd;
    logic           t_re;
    logic [TAW-1:0] t_ra;
    logic           l_we;
    logic [NW-1:0]  l_wa;
    logic [NW-1:0]  l_wd;
    logic           l_re;
    logic [NW-1:0]  l_ra;
    logic           s_we;
    logic [NW-1:0]  s_wa;
    logic [NW-1:0]  s_wd;
    logic           s_re;
    logic [NW-1:0]  s_ra;

    assign len_val = len_zero_reg ? '0 : len_rdata_reg;
    assign sym_bad = (32'(symbol) >= 32'(ALPHABET));
    assign no_room = ((CW + 1)'(cnt_reg) + (CW + 1)'(2)) > (CW + 1)'(MAX_NODES);

    always_comb
    begin
        t_we = 1'b1;
        t_wa = clr_reg;
        t_wd = '0;
        priority if (cmd.t_clr)
        begin
            t_wa = clr_reg;
            t_wd = '0;
        end
        else if (cmd.t_wr_nn)
        begin
            t_wa = tab_addr(p_reg, IW'(c_reg));
            t_wd = nn_reg;
        end
        else if (cmd.t_wr_k)
        begin
            t_wa = tab_addr(p_reg, IW'(c_reg));
            t_wd = k_reg;
        end
        else if (cmd.t_copy && (idx_reg != '0))
        begin
            t_wa = tab_addr(k_reg, idx_reg - IW'(1));
            t_wd = tab_rdata_reg;
        end
        else
        begin
            t_we = 1'b0;
        end

        t_re = 1'b1;
        t_ra = tab_addr(p_reg, IW'(c_reg));
        priority if (cmd.t_rd_pc)
        begin
            t_ra = tab_addr(p_reg, IW'(c_reg));
        end
        else if (cmd.t_copy && (idx_reg != IW'(ALPHABET)))
        begin
            t_ra = tab_addr(q_reg, idx_reg);
        end
        else
        begin
            t_re = 1'b0;
        end

        l_we = cmd.alloc_nn || cmd.l_wr_k;
        l_wa = cmd.alloc_nn ? cnt_reg[NW-1:0] : k_reg;
        l_wd = cmd.alloc_nn ? (len_val + NW'(1)) : want_reg;
        l_re = cmd.l_rd_p || cmd.l_rd_q;
        l_ra = cmd.l_rd_q ? q_reg : p_reg;

        s_we = 1'b1;
        s_wa = nn_reg;
        s_wd = '0;
        priority if (cmd.s_wr_nn_zero)
        begin
            s_wa = nn_reg;
            s_wd = '0;
        end
        else if (cmd.s_wr_k_q)
        begin
            s_wa = k_reg;
            s_wd = link_rdata_reg;
        end
        else if (cmd.s_wr_q_k)
        begin
            s_wa = q_reg;
            s_wd = k_reg;
        end
        else if (cmd.s_wr_nn_ret)
        begin
            s_wa = nn_reg;
            s_wd = r_reg;
        end
        else
        begin
            s_we = 1'b0;
        end
        s_re = cmd.s_rd_p || cmd.s_rd_q;
        s_ra = cmd.s_rd_q ? q_reg : p_reg;
    end

    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            tab_mem[t_wa] <= t_wd;
        end
        if (t_re)
        begin
            tab_rdata_reg <= tab_mem[t_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (l_we)
        begin
            len_mem[l_wa] <= l_wd;
        end
        if (l_re)
        begin
            len_rdata_reg <= len_mem[l_ra];
            len_zero_reg  <= (l_ra == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            link_mem[s_wa] <= s_wd;
        end
        if (s_re)
        begin
            link_rdata_reg <= link_mem[s_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            c_reg <= AW'(symbol);
            p_reg <= restart ? '0 : cur_reg;
        end
        else if (cmd.p_link)
        begin
            p_reg <= link_rdata_reg;
        end
        if (cmd.alloc_nn)
        begin
            nn_reg     <= cnt_reg[NW-1:0];
            nn_len_reg <= len_val + NW'(1);
        end
        if (cmd.set_q)
        begin
            q_reg <= tab_rdata_reg;
        end
        if (cmd.set_want)
        begin
            want_reg <= len_val + NW'(1);
        end
        if (cmd.alloc_k)
        begin
            k_reg <= cnt_reg[NW-1:0];
        end
        if (cmd.alloc_k)
        begin
            idx_reg <= '0;
        end
        else if (cmd.t_copy)
        begin
            idx_reg <= idx_reg + IW'(1);
        end
        priority if (cmd.ret_nn)
        begin
            r_reg     <= nn_reg;
            r_len_reg <= nn_len_reg;
        end
        else if (cmd.ret_q)
        begin
            r_reg     <= q_reg;
            r_len_reg <= len_val;
        end
        else if (cmd.ret_k)
        begin
            r_reg     <= k_reg;
            r_len_reg <= want_reg;
        end
        if (cmd.emit)
        begin
            if (skip_reg || full_reg)
            begin
                end_state  <= END_STATE_W'(cur_reg);
                end_length <= END_LENGTH_W'(cur_len_reg);
            end
            else
            begin
                end_state  <= END_STATE_W'(r_reg);
                end_length <= END_LENGTH_W'(r_len_reg);
            end
            node_total <= NODE_TOTAL_W'(cnt_reg);
            full_res   <= full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            cnt_reg       <= CW'(1);
            cur_reg       <= '0;
            cur_len_reg   <= '0;
            skip_reg      <= 1'b0;
            full_reg      <= 1'b0;
            fresh_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.t_clr)
            begin
                clr_reg <= clr_reg + TAW'(1);
            end
            if (cmd.load)
            begin
                skip_reg  <= sym_bad;
                full_reg  <= !sym_bad && no_room;
                fresh_reg <= 1'b0;
            end
            else if (cmd.alloc_nn)
            begin
                fresh_reg <= 1'b1;
            end
            if (cmd.alloc_nn || cmd.alloc_k)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.emit && !skip_reg && !full_reg)
            begin
                cur_reg     <= r_reg;
                cur_len_reg <= r_len_reg;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

    assign st.clr_last  = (clr_reg == TAW'(TDEPTH - 1));
    assign st.refused   = skip_reg || full_reg;
    assign st.edge_zero = (tab_rdata_reg == '0);
    assign st.edge_is_q = (tab_rdata_reg == q_reg);
    assign st.p_root    = (p_reg == '0);
    assign st.len_ok    = (len_val <= want_reg);
    assign st.copy_last = (idx_reg == IW'(ALPHABET));
    assign st.fresh     = fresh_reg;
    assign st.out_free  = !out_valid_reg || out_ready;

    a_room_on_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.alloc_nn || cmd.alloc_k) |-> (cnt_reg < CW'(MAX_NODES)))
        else $error("node allocated beyond the table");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_NODES))
        else $error("node count beyond the table");

    a_one_tab_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.t_clr, cmd.t_wr_nn, cmd.t_wr_k, cmd.t_copy}))
        else $error("competing transition table writes");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result word overwritten before it was taken");
endmodule

### rtl/suffix_automaton_builder_top.sv
// ----------------------------------------------------------------------------
// Suffix automaton builder
// Builds a generalised suffix automaton online, one symbol word at a time.
// ----------------------------------------------------------------------------
// The request channel takes one word per symbol: the symbol index and a
// restart flag that begins a new string at the root. For every accepted word
// one word leaves on the result channel: the end node, its length, the node
// count and a flag set when the symbol was refused for lack of two free nodes.
// After reset the transition table is cleared, one entry per cycle, over all
// MAX_NODES * ALPHABET entries; no word is accepted until that pass ends.
// One word is processed at a time. A refused or out-of-range symbol goes
// straight to its result; otherwise the edge from the current node is read,
// and a fresh node walks the suffix links writing edges until it meets an
// existing edge or the root. A non-solid edge is cloned, its row copied and
// the edges to the old node redirected. The transition memory allows one
// read and one write per cycle. The next word is accepted while the previous
// result still waits in its output register; a stalled receiver holds the
// block only when a new result is ready to be written.
// ----------------------------------------------------------------------------
module suffix_automaton_builder_top #(
    parameter int MAX_NODES = sab_pkg::DEF_MAX_NODES,
    parameter int ALPHABET  = sab_pkg::DEF_ALPHABET
)
(
    input  logic      clk,
    input  logic      rst_n,
    sab_in_if.sink    request,
    sab_out_if.source result
);
    import sab_pkg::*;

    cmd_t    cmd;
    status_t st;

    sab_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .st       (st),
        .cmd      (cmd)
    );

    sab_datapath #(
        .MAX_NODES (MAX_NODES),
        .ALPHABET  (ALPHABET)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .symbol     (request.symbol),
        .restart    (request.restart),
        .out_ready  (result.ready),
        .out_valid  (result.valid),
        .end_state  (result.end_state),
        .end_length (result.end_length),
        .node_total (result.node_total),
        .full_res   (result.full_res)
    );
endmodule
